[hw/rtl/apc_pkg.sv]
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constants of the application protocol classifier:
// per-payload tracking state, port settings, class codes and SIP prefixes.
// ----------------------------------------------------------------------------
package apc_pkg;

	// class codes
	localparam logic [2:0] CLASS_NONE  = 3'd0;
	localparam logic [2:0] CLASS_DHCP  = 3'd1;
	localparam logic [2:0] CLASS_QUIC  = 3'd2;
	localparam logic [2:0] CLASS_MQTT  = 3'd3;
	localparam logic [2:0] CLASS_VXLAN = 3'd4;
	localparam logic [2:0] CLASS_SIP   = 3'd5;

	// transport kinds
	localparam logic [1:0] XPORT_UDP = 2'd1;
	localparam logic [1:0] XPORT_TCP = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_DHCP_SERVER = 3'd0;
	localparam logic [2:0] REG_DHCP_CLIENT = 3'd1;
	localparam logic [2:0] REG_QUIC        = 3'd2;
	localparam logic [2:0] REG_MQTT        = 3'd3;
	localparam logic [2:0] REG_VXLAN       = 3'd4;
	localparam logic [2:0] REG_SIP         = 3'd5;

	// port reset values
	localparam logic [15:0] RST_DHCP_SERVER = 16'd67;
	localparam logic [15:0] RST_DHCP_CLIENT = 16'd68;
	localparam logic [15:0] RST_QUIC        = 16'd443;
	localparam logic [15:0] RST_MQTT        = 16'd1883;
	localparam logic [15:0] RST_VXLAN       = 16'd4789;
	localparam logic [15:0] RST_SIP         = 16'd5060;

	// header constants
	localparam logic [31:0] DHCP_COOKIE  = 32'h63825363;
	localparam logic [31:0] QUIC_V_NEG   = 32'h00000000;
	localparam logic [31:0] QUIC_V1      = 32'h00000001;
	localparam logic [31:0] QUIC_V2      = 32'h6b3343cf;
	localparam logic [31:0] QUIC_DRAFT29 = 32'hff00001d;
	localparam logic [31:0] QUIC_DRAFT32 = 32'hff000020;
	localparam logic [3:0]  MQTT_TYPE_BAD = 4'hf;
	localparam logic [7:0]  COUNT_MAX    = 8'd255;

	// sip prefixes, left aligned in 10 bytes
	localparam int SIP_COUNT = 14;
	localparam logic [79:0] SIP_TEXT [0:SIP_COUNT-1] = '{
		{"INVITE ",    24'h0},
		{"ACK ",       48'h0},
		{"BYE ",       48'h0},
		{"CANCEL ",    24'h0},
		{"REGISTER ",   8'h0},
		{"OPTIONS ",   16'h0},
		{"PRACK ",     32'h0},
		{"SUBSCRIBE "},
		{"NOTIFY ",    24'h0},
		{"PUBLISH ",   16'h0},
		{"INFO ",      40'h0},
		{"REFER ",     32'h0},
		{"MESSAGE ",   16'h0},
		{"SIP/2.0 ",   16'h0}
	};
	localparam logic [7:0] SIP_LEN [0:SIP_COUNT-1] = '{
		8'd7, 8'd4, 8'd4, 8'd7, 8'd9, 8'd8, 8'd6,
		8'd10, 8'd7, 8'd8, 8'd5, 8'd6, 8'd8, 8'd8
	};

	// per-payload tracking state
	typedef struct packed {
		logic [7:0]           count;
		logic [7:0]           first_hdr;
		logic [31:0]          version;
		logic [31:0]          cookie;
		logic                 len_cont;
		logic [SIP_COUNT-1:0] live;
		logic                 matched;
	} flow_state_t;

	localparam flow_state_t FLOW_CLEAR = '{
		count:     8'd0,
		first_hdr: 8'd0,
		version:   32'd0,
		cookie:    32'd0,
		len_cont:  1'b1,
		live:      {SIP_COUNT{1'b1}},
		matched:   1'b0
	};

	// configured ports
	typedef struct packed {
		logic [15:0] dhcp_server;
		logic [15:0] dhcp_client;
		logic [15:0] quic;
		logic [15:0] mqtt;
		logic [15:0] vxlan;
		logic [15:0] sip;
	} port_cfg_t;

	// character of prefix k at byte position pos (pos below its length)
	function automatic logic [7:0] sip_char(input logic [79:0] text, input logic [3:0] pos);
		logic [79:0] t;
		t = text << {pos, 3'b000};
		return t[79:72];
	endfunction

endpackage

[hw/rtl/apc_track.sv]
// ----------------------------------------------------------------------------
// apc_track
// Per-payload state update for one transaction: clear on first item, then
// fold in the payload byte (header capture, cookie capture, sip prefixes).
// ----------------------------------------------------------------------------
module apc_track import apc_pkg::*; (
	input  flow_state_t cur,
	input  logic        first_item,
	input  logic        has_byte,
	input  logic [7:0]  payload_byte,
	output flow_state_t upd
);

	flow_state_t base;

	// start from a clean state on the first item
	assign base = first_item ? FLOW_CLEAR : cur;

	// byte update, frozen once the counter saturates
	always_comb begin
		upd = base;
		if (has_byte && base.count != COUNT_MAX) begin
			if (base.count == 8'd0) begin
				upd.first_hdr = payload_byte;
			end
			if (base.count >= 8'd1 && base.count <= 8'd4) begin
				upd.version  = {base.version[23:0], payload_byte};
				upd.len_cont = base.len_cont & payload_byte[7];
			end
			if (base.count >= 8'd236 && base.count <= 8'd239) begin
				upd.cookie = {base.cookie[23:0], payload_byte};
			end
			for (int k = 0; k < SIP_COUNT; k++) begin
				if (base.count < SIP_LEN[k]) begin
					if (payload_byte != sip_char(SIP_TEXT[k], base.count[3:0])) begin
						upd.live[k] = 1'b0;
					end else if (base.count == SIP_LEN[k] - 8'd1 && base.live[k]) begin
						upd.matched = 1'b1;
					end
				end
			end
			upd.count = base.count + 8'd1;
		end
	end

endmodule

[hw/rtl/apc_decide.sv]
// ----------------------------------------------------------------------------
// apc_decide
// Decoder checks on the updated payload state and the priority pick of
// the class for UDP and TCP.
// ----------------------------------------------------------------------------
module apc_decide import apc_pkg::*; (
	input  flow_state_t st,
	input  logic [15:0] flow_src,
	input  logic [15:0] flow_dst,
	input  logic [1:0]  transport,
	input  port_cfg_t   cfg,
	output logic [2:0]  cls
);

	logic hit_dhcp, hit_quic, hit_mqtt, hit_vxlan, hit_sip;
	logic is_dhcp, is_quic, is_mqtt, is_vxlan, is_sip;
	logic ver_ok;
	logic [3:0] mqtt_type;

	// port matches
	assign hit_dhcp  = flow_src == cfg.dhcp_server || flow_dst == cfg.dhcp_server ||
	                   flow_src == cfg.dhcp_client || flow_dst == cfg.dhcp_client;
	assign hit_quic  = flow_src == cfg.quic  || flow_dst == cfg.quic;
	assign hit_mqtt  = flow_src == cfg.mqtt  || flow_dst == cfg.mqtt;
	assign hit_vxlan = flow_src == cfg.vxlan || flow_dst == cfg.vxlan;
	assign hit_sip   = flow_src == cfg.sip   || flow_dst == cfg.sip;

	// decoder checks
	assign ver_ok    = st.version == QUIC_V_NEG || st.version == QUIC_V1 ||
	                   st.version == QUIC_V2 || st.version == QUIC_DRAFT29 ||
	                   st.version == QUIC_DRAFT32;
	assign mqtt_type = st.first_hdr[7:4];
	assign is_dhcp   = hit_dhcp && st.count >= 8'd240 && st.cookie == DHCP_COOKIE;
	assign is_quic   = hit_quic && st.count >= 8'd6 &&
	                   (st.first_hdr[7] ? ver_ok : st.first_hdr[6]);
	assign is_mqtt   = hit_mqtt && st.count >= 8'd2 && mqtt_type != 4'd0 &&
	                   mqtt_type != MQTT_TYPE_BAD && !(st.count >= 8'd5 && st.len_cont);
	assign is_vxlan  = hit_vxlan && st.count >= 8'd8 && st.first_hdr[3];
	assign is_sip    = hit_sip && st.matched;

	// priority pick per transport
	always_comb begin
		cls = CLASS_NONE;
		unique case (transport)
			XPORT_UDP: begin
				if (is_dhcp)       cls = CLASS_DHCP;
				else if (is_quic)  cls = CLASS_QUIC;
				else if (is_mqtt)  cls = CLASS_MQTT;
				else if (is_vxlan) cls = CLASS_VXLAN;
			end
			XPORT_TCP: begin
				if (is_sip)       cls = CLASS_SIP;
				else if (is_mqtt) cls = CLASS_MQTT;
			end
			default: cls = CLASS_NONE;
		endcase
	end

endmodule

[hw/rtl/app_protocol_classifier.sv]
// ----------------------------------------------------------------------------
// app_protocol_classifier
// Streaming classifier of transport payloads into application protocols.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one payload byte per
//   transaction with has_byte, first_item, last_item; ports and transport
//   kind are sampled on first_item. Output channel (out_valid / out_stall)
//   carries one transaction per payload, given for its last item:
//   protocol_class and claimed.
//   Config writes (cfg_wr_en, cfg_index, cfg_data) set the six port
//   registers; indexes above 5 are ignored. Write only while idle.
//   Result path: a last item passes the input register, then the result
//   register, which raises out_valid; a stalled full result register holds it.
//   Throughput: one input transaction per cycle while in_stall is low, set
//   by the single pass of state update and decoder logic between the registers.
//   Reset: clears the payload state, held ports, both registers' valid
//   flags and loads the default port values.
//   Stall: while the result register is full and stalled, a last item in
//   the input register waits and in_stall rises; other items keep flowing.
// ----------------------------------------------------------------------------
module app_protocol_classifier import apc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  payload_byte,
	input  logic        has_byte,
	input  logic        first_item,
	input  logic        last_item,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic [1:0]  transport_kind,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  protocol_class,
	output logic        claimed
);

	port_cfg_t   cfg_q;
	flow_state_t state_q;
	flow_state_t state_upd;
	logic [15:0] src_q, dst_q;
	logic [1:0]  xport_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        has_s1, first_s1, last_s1;
	logic [15:0] src_s1, dst_s1;
	logic [1:0]  xport_s1;

	logic        out_valid_q;
	logic [2:0]  class_q;
	logic        in_acc, adv_s1;
	logic [15:0] src_eff, dst_eff;
	logic [1:0]  xport_eff;
	logic [2:0]  cls;

	// handshake
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dhcp_server <= RST_DHCP_SERVER;
			cfg_q.dhcp_client <= RST_DHCP_CLIENT;
			cfg_q.quic        <= RST_QUIC;
			cfg_q.mqtt        <= RST_MQTT;
			cfg_q.vxlan       <= RST_VXLAN;
			cfg_q.sip         <= RST_SIP;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DHCP_SERVER: cfg_q.dhcp_server <= cfg_data;
				REG_DHCP_CLIENT: cfg_q.dhcp_client <= cfg_data;
				REG_QUIC:        cfg_q.quic        <= cfg_data;
				REG_MQTT:        cfg_q.mqtt        <= cfg_data;
				REG_VXLAN:       cfg_q.vxlan       <= cfg_data;
				REG_SIP:         cfg_q.sip         <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register, valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register, payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1  <= payload_byte;
			has_s1   <= has_byte;
			first_s1 <= first_item;
			last_s1  <= last_item;
			src_s1   <= source_port;
			dst_s1   <= dest_port;
			xport_s1 <= transport_kind;
		end
	end

	// ports and transport seen by this transaction
	assign src_eff   = first_s1 ? src_s1 : src_q;
	assign dst_eff   = first_s1 ? dst_s1 : dst_q;
	assign xport_eff = first_s1 ? xport_s1 : xport_q;

	apc_track u_track (
		.cur          (state_q),
		.first_item   (first_s1),
		.has_byte     (has_s1),
		.payload_byte (byte_s1),
		.upd          (state_upd)
	);

	apc_decide u_decide (
		.st        (state_upd),
		.flow_src  (src_eff),
		.flow_dst  (dst_eff),
		.transport (xport_eff),
		.cfg       (cfg_q),
		.cls       (cls)
	);

	// payload state and held ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FLOW_CLEAR;
			src_q   <= 16'd0;
			dst_q   <= 16'd0;
			xport_q <= 2'd0;
		end else if (adv_s1) begin
			state_q <= last_s1 ? FLOW_CLEAR : state_upd;
			src_q   <= src_eff;
			dst_q   <= dst_eff;
			xport_q <= xport_eff;
		end
	end

	// result register, valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register, payload
	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			class_q <= cls;
		end
	end

	assign out_valid      = out_valid_q;
	assign protocol_class = class_q;
	assign claimed        = class_q != CLASS_NONE;

endmodule

[test/app_protocol_classifier_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// app_protocol_classifier_test
// Self-checking bench for the application protocol classifier. Payloads are
// streamed one byte per transaction with random sender gaps and output
// stalls. A predictor inside the bench follows every accepted transaction
// and queues the class each payload must get. Every result is checked in
// order against that queue. Directed cases come first, then long DHCP
// payloads, then random traffic under several port settings.
// ----------------------------------------------------------------------------
module app_protocol_classifier_test import apc_pkg::*; ();

	localparam int CLK_HALF = 6;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_CAP = 100;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam logic [1:0] XPORT_OTHER = 2'd0;
	localparam logic [1:0] XPORT_ODD = 2'd3;

	typedef logic [7:0] byte_q_t [$];

	typedef struct packed {
		logic [7:0]  data;
		logic        has;
		logic        opens;
		logic        closes;
		logic [15:0] src;
		logic [15:0] dst;
		logic [1:0]  xport;
	} beat_t;

	typedef struct packed {
		logic [2:0] proto;
		logic       claimed;
	} verdict_t;

	// dut signals
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  payload_byte = '0;
	logic        has_byte = 1'b0;
	logic        first_item = 1'b0;
	logic        last_item = 1'b0;
	logic [15:0] source_port = '0;
	logic [15:0] dest_port = '0;
	logic [1:0]  transport_kind = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  protocol_class;
	logic        claimed;

	// bench state
	int send_idle_pct = 0;
	int stall_pct = 0;
	int beats_sent = 0;
	int verdicts_checked = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	verdict_t expected_verdicts [$];

	// predictor state
	logic [15:0] port_cfg [0:5];
	logic [7:0]  seen_count;
	logic [7:0]  lead_byte;
	logic [31:0] version_bytes;
	logic [31:0] cookie_bytes;
	logic        all_continued;
	logic [13:0] methods_alive;
	logic        method_hit;
	logic [15:0] held_src;
	logic [15:0] held_dst;
	logic [1:0]  held_kind;

	app_protocol_classifier dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.payload_byte   (payload_byte),
		.has_byte       (has_byte),
		.first_item     (first_item),
		.last_item      (last_item),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.transport_kind (transport_kind),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.protocol_class (protocol_class),
		.claimed        (claimed)
	);

	// clock
	initial forever #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic string sip_prefix(input int k);
		case (k)
			0: return "INVITE ";
			1: return "ACK ";
			2: return "BYE ";
			3: return "CANCEL ";
			4: return "REGISTER ";
			5: return "OPTIONS ";
			6: return "PRACK ";
			7: return "SUBSCRIBE ";
			8: return "NOTIFY ";
			9: return "PUBLISH ";
			10: return "INFO ";
			11: return "REFER ";
			12: return "MESSAGE ";
			default: return "SIP/2.0 ";
		endcase
	endfunction

	function automatic void clear_flow();
		seen_count = '0;
		lead_byte = '0;
		version_bytes = '0;
		cookie_bytes = '0;
		all_continued = 1'b1;
		methods_alive = '1;
		method_hit = 1'b0;
	endfunction

	function automatic bit on_port(input logic [15:0] p);
		return held_src == p || held_dst == p;
	endfunction

	// fold one payload byte into the header trackers
	function automatic void track_byte(input logic [7:0] b);
		int pos;
		int k;
		string s;
		pos = int'(seen_count);
		if (pos >= 255)
			return;
		if (pos == 0)
			lead_byte = b;
		if (pos >= 1 && pos <= 4) begin
			version_bytes = {version_bytes[23:0], b};
			all_continued = all_continued & b[7];
		end
		if (pos >= 236 && pos <= 239)
			cookie_bytes = {cookie_bytes[23:0], b};
		// prefix matching, one bit per method
		for (k = 0; k < 14; k++) begin
			s = sip_prefix(k);
			if (pos < s.len()) begin
				if (b != s[pos])
					methods_alive[k] = 1'b0;
				else if (pos + 1 == s.len() && methods_alive[k])
					method_hit = 1'b1;
			end
		end
		seen_count = 8'(pos + 1);
	endfunction

	// class of the payload collected so far
	function automatic logic [2:0] payload_class();
		logic [3:0] type_nib;
		bit dhcp;
		bit quic;
		bit mqtt;
		bit vxlan;
		bit sip;
		type_nib = lead_byte[7:4];
		dhcp = (on_port(port_cfg[REG_DHCP_SERVER]) || on_port(port_cfg[REG_DHCP_CLIENT])) &&
			seen_count >= 240 && cookie_bytes == DHCP_COOKIE;
		if (lead_byte[7])
			quic = version_bytes == QUIC_V_NEG || version_bytes == QUIC_V1 ||
				version_bytes == QUIC_V2 || version_bytes == QUIC_DRAFT29 ||
				version_bytes == QUIC_DRAFT32;
		else
			quic = lead_byte[6];
		quic = quic && seen_count >= 6 && on_port(port_cfg[REG_QUIC]);
		mqtt = on_port(port_cfg[REG_MQTT]) && seen_count >= 2 && type_nib != 4'h0 &&
			type_nib != MQTT_TYPE_BAD && !(seen_count >= 5 && all_continued);
		vxlan = on_port(port_cfg[REG_VXLAN]) && seen_count >= 8 && lead_byte[3];
		sip = on_port(port_cfg[REG_SIP]) && method_hit;
		if (held_kind == XPORT_UDP) begin
			if (dhcp) return CLASS_DHCP;
			if (quic) return CLASS_QUIC;
			if (mqtt) return CLASS_MQTT;
			if (vxlan) return CLASS_VXLAN;
		end else if (held_kind == XPORT_TCP) begin
			if (sip) return CLASS_SIP;
			if (mqtt) return CLASS_MQTT;
		end
		return CLASS_NONE;
	endfunction

	// follow one accepted transaction
	function automatic void follow_beat(input beat_t bt);
		verdict_t v;
		if (bt.opens) begin
			clear_flow();
			held_src = bt.src;
			held_dst = bt.dst;
			held_kind = bt.xport;
		end
		if (bt.has)
			track_byte(bt.data);
		if (bt.closes) begin
			v.proto = payload_class();
			v.claimed = v.proto != CLASS_NONE;
			expected_verdicts.push_back(v);
			clear_flow();
		end
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (error_count < REPORT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	// output side: random stall
	always @(posedge clk)
		out_stall <= int'($urandom_range(99)) < stall_pct;

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0)
				report_mismatch($sformatf("class %0d given with no payload pending",
					protocol_class));
			else begin
				want = expected_verdicts.pop_front();
				if (protocol_class !== want.proto)
					report_mismatch($sformatf("result %0d protocol_class %0d, want %0d",
						verdicts_checked, protocol_class, want.proto));
				if (claimed !== want.claimed)
					report_mismatch($sformatf("result %0d claimed %0b, want %0b",
						verdicts_checked, claimed, want.claimed));
			end
			verdicts_checked++;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no transaction for %0d cycles", $time, quiet_cycles);
			$display("app_protocol_classifier_test NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	// drive one transaction and wait until it is taken
	task automatic send_beat(input beat_t bt);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		payload_byte <= bt.data;
		has_byte <= bt.has;
		first_item <= bt.opens;
		last_item <= bt.closes;
		source_port <= bt.src;
		dest_port <= bt.dst;
		transport_kind <= bt.xport;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		follow_beat(bt);
		beats_sent++;
	endtask

	// stream one payload, with optional byte-less transactions mixed in
	task automatic send_payload(input byte_q_t q, input logic [15:0] src,
			input logic [15:0] dst, input logic [1:0] xport, input bit opener,
			input int blank_pct);
		beat_t beats [$];
		beat_t bt;
		int i;
		for (i = 0; i <= q.size(); i++) begin
			bt.data = 8'($urandom_range(255));
			bt.src = 16'($urandom_range(65535));
			bt.dst = 16'($urandom_range(65535));
			bt.xport = 2'($urandom_range(3));
			bt.opens = 1'b0;
			bt.closes = 1'b0;
			bt.has = 1'b0;
			if (int'($urandom_range(99)) < blank_pct || (i == q.size() && beats.size() == 0))
				beats.push_back(bt);
			if (i < q.size()) begin
				bt.has = 1'b1;
				bt.data = q[i];
				beats.push_back(bt);
			end
		end
		for (i = 0; i < beats.size(); i++) begin
			bt = beats[i];
			bt.opens = opener && i == 0;
			bt.closes = i == beats.size() - 1;
			if (i == 0) begin
				bt.src = src;
				bt.dst = dst;
				bt.xport = xport;
			end
			send_beat(bt);
		end
	endtask

	// stop input, let every result come out, then let the pipeline empty
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_port(input logic [2:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx <= REG_SIP)
			port_cfg[idx] = value;
	endtask

	task automatic load_ports(input logic [15:0] server, input logic [15:0] client,
			input logic [15:0] quic, input logic [15:0] mqtt, input logic [15:0] vxlan,
			input logic [15:0] sip);
		write_port(REG_DHCP_SERVER, server);
		write_port(REG_DHCP_CLIENT, client);
		write_port(REG_QUIC, quic);
		write_port(REG_MQTT, mqtt);
		write_port(REG_VXLAN, vxlan);
		write_port(REG_SIP, sip);
	endtask

	// dhcp body of n bytes, cookie in place when asked
	task automatic dhcp_bytes(input int n, input bit good, output byte_q_t q);
		int i;
		q.delete();
		for (i = 0; i < n; i++)
			if (good && i >= 236 && i <= 239)
				q.push_back(DHCP_COOKIE[31 - 8 * (i - 236) -: 8]);
			else
				q.push_back(8'($urandom_range(255)));
	endtask

	task automatic text_bytes(input string s, output byte_q_t q);
		int i;
		q.delete();
		for (i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endtask

	// one random payload, mostly shaped after one of the decoders
	task automatic build_payload(output byte_q_t q, output logic [15:0] src,
			output logic [15:0] dst, output logic [1:0] xport);
		int pick;
		int n;
		int i;
		int cut;
		logic [15:0] home;
		logic [39:0] hdr;
		logic [31:0] ver;
		string s;
		q.delete();
		xport = XPORT_UDP;
		pick = $urandom_range(99);
		if (pick < 1) begin
			home = $urandom_range(1) ? port_cfg[REG_DHCP_SERVER] : port_cfg[REG_DHCP_CLIENT];
			dhcp_bytes($urandom_range(242, 238), $urandom_range(3) != 0, q);
		end else if (pick < 22) begin
			// quic: long header with a listed or random version, or short header
			home = port_cfg[REG_QUIC];
			case ($urandom_range(5))
				0: ver = QUIC_V_NEG;
				1: ver = QUIC_V1;
				2: ver = QUIC_V2;
				3: ver = QUIC_DRAFT29;
				4: ver = QUIC_DRAFT32;
				default: ver = $urandom;
			endcase
			hdr = {8'($urandom_range(255)), ver};
			n = ($urandom_range(3) == 0) ? $urandom_range(5) : $urandom_range(10, 6);
			for (i = 0; i < n; i++)
				q.push_back(i < 5 ? hdr[39 - 8 * i -: 8] : 8'($urandom_range(255)));
		end else if (pick < 42) begin
			// mqtt: any type nibble, length bytes mostly continued
			home = port_cfg[REG_MQTT];
			xport = $urandom_range(1) ? XPORT_UDP : XPORT_TCP;
			n = $urandom_range(7);
			for (i = 0; i < n; i++)
				if (i >= 1 && i <= 4)
					q.push_back({$urandom_range(3) != 0, 7'($urandom_range(127))});
				else
					q.push_back(8'($urandom_range(255)));
		end else if (pick < 57) begin
			// vxlan: flag bit random, length around the minimum
			home = port_cfg[REG_VXLAN];
			n = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(12, 8);
			for (i = 0; i < n; i++)
				q.push_back(8'($urandom_range(255)));
		end else if (pick < 80) begin
			// sip: a method or response prefix, sometimes cut short or damaged
			home = port_cfg[REG_SIP];
			xport = XPORT_TCP;
			s = sip_prefix($urandom_range(13));
			cut = ($urandom_range(4) == 0) ? $urandom_range(s.len() - 1) : s.len();
			for (i = 0; i < cut; i++)
				q.push_back(s[i]);
			if (cut > 0 && $urandom_range(7) == 0)
				q[$urandom_range(cut - 1)] = 8'($urandom_range(255));
			n = $urandom_range(4);
			for (i = 0; i < n; i++)
				q.push_back(8'($urandom_range(255)));
		end else begin
			// noise on any port and transport
			home = 16'($urandom_range(65535));
			xport = 2'($urandom_range(3));
			n = $urandom_range(6);
			for (i = 0; i < n; i++)
				q.push_back(8'($urandom_range(255)));
		end
		// ports: usually the decoder's own on one side, sometimes a second known port
		src = 16'($urandom_range(65535));
		dst = 16'($urandom_range(65535));
		pick = $urandom_range(9);
		if (pick < 7) begin
			if ($urandom_range(1))
				src = home;
			else
				dst = home;
		end else if (pick < 9) begin
			src = home;
			dst = port_cfg[3'($urandom_range(5))];
		end
		if ($urandom_range(99) < 12)
			xport = 2'($urandom_range(3));
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// one short payload per decoder outcome and per ordering case
	task automatic test_directed_cases();
		byte_q_t q;
		// empty payload, length zero
		q.delete();
		send_payload(q, 16'd50000, RST_QUIC, XPORT_UDP, 1'b1, 0);
		// quic long header, version 1
		q = '{8'hC3, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5A};
		send_payload(q, RST_QUIC, 16'hFFFF, XPORT_UDP, 1'b1, 0);
		// quic short header with the fixed bit
		q = '{8'h7F, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
		send_payload(q, 16'h0000, RST_QUIC, XPORT_UDP, 1'b1, 0);
		// mqtt with the reserved type nibble
		q = '{8'hF0, 8'h00};
		send_payload(q, RST_MQTT, 16'd1, XPORT_TCP, 1'b1, 0);
		// mqtt with four continued length bytes
		q = '{8'h30, 8'h80, 8'hFF, 8'h90, 8'hA0};
		send_payload(q, 16'd2, RST_MQTT, XPORT_TCP, 1'b1, 0);
		// payload without a first item reuses the held ports
		q = '{8'h10, 8'h02};
		send_payload(q, 16'd7, 16'd9, XPORT_OTHER, 1'b0, 0);
		// vxlan with byte-less transactions in between
		q = '{8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h00};
		send_payload(q, 16'd3, RST_VXLAN, XPORT_UDP, 1'b1, 40);
		// sip request on tcp
		text_bytes("ACK ", q);
		send_payload(q, RST_SIP, 16'd5061, XPORT_TCP, 1'b1, 0);
		// transport kind 3 is never classified
		text_bytes("BYE ", q);
		send_payload(q, RST_SIP, RST_SIP, XPORT_ODD, 1'b1, 0);
	endtask

	// payloads long enough for dhcp, including counter saturation
	task automatic test_dhcp_long();
		byte_q_t q;
		dhcp_bytes(240, 1'b1, q);
		send_payload(q, RST_DHCP_CLIENT, RST_DHCP_SERVER, XPORT_UDP, 1'b1, 0);
		// bytes past the counter limit are ignored
		dhcp_bytes(262, 1'b1, q);
		send_payload(q, 16'd1234, RST_DHCP_CLIENT, XPORT_UDP, 1'b1, 2);
		// one byte short of the minimum
		dhcp_bytes(239, 1'b1, q);
		send_payload(q, RST_DHCP_SERVER, 16'd4321, XPORT_UDP, 1'b1, 0);
	endtask

	task automatic test_random_traffic(input int beat_goal);
		byte_q_t q;
		logic [15:0] src;
		logic [15:0] dst;
		logic [1:0] xport;
		int stop_at;
		stop_at = beats_sent + beat_goal;
		while (beats_sent < stop_at) begin
			build_payload(q, src, dst, xport);
			send_payload(q, src, dst, xport, $urandom_range(29) != 0, 6);
		end
	endtask

	// traffic under extreme and random port settings, ignored indexes too
	task automatic test_port_settings();
		drain_results();
		// all ports equal: decoder order decides
		load_ports(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		write_port(REG_SPARE_LO, 16'hFFFF);
		write_port(REG_SPARE_HI, 16'hFFFF);
		test_random_traffic(50);
		drain_results();
		load_ports(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		write_port(REG_SPARE_LO, 16'h0000);
		write_port(REG_SPARE_HI, 16'h0000);
		test_random_traffic(50);
		drain_results();
		load_ports(16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)));
		test_random_traffic(50);
		drain_results();
		load_ports(RST_DHCP_SERVER, RST_DHCP_CLIENT, RST_QUIC, RST_MQTT, RST_VXLAN, RST_SIP);
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		port_cfg[REG_DHCP_SERVER] = RST_DHCP_SERVER;
		port_cfg[REG_DHCP_CLIENT] = RST_DHCP_CLIENT;
		port_cfg[REG_QUIC] = RST_QUIC;
		port_cfg[REG_MQTT] = RST_MQTT;
		port_cfg[REG_VXLAN] = RST_VXLAN;
		port_cfg[REG_SIP] = RST_SIP;
		clear_flow();
		held_src = '0;
		held_dst = '0;
		held_kind = '0;
		send_idle_pct = 28;
		stall_pct = 74;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_dhcp_long();
		test_random_traffic(110);

		send_idle_pct = 74;
		stall_pct = 28;
		test_port_settings();

		send_idle_pct = 0;
		stall_pct = 0;
		test_random_traffic(80);

		drain_results();
		if (error_count == 0)
			$display("app_protocol_classifier_test OK");
		else
			$display("app_protocol_classifier_test NOT OK");
		$finish;
	end

endmodule
